>>> hw/rtl/scfr_pkg.sv
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared types, constants and the CRC16-CCITT byte step for the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package scfr_pkg;

    // Default largest payload a frame may carry.
    localparam int unsigned MAX_PAYLOAD_DEF = 160;

    // Receive buffer depth, fixed by the 8-bit byte count.
    localparam int unsigned BUF_DEPTH = 256;

    // Frame layout constants.
    localparam logic [7:0]  HDR_BYTES = 8'd8;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    // Reset values of the configuration registers.
    localparam logic [7:0] SYNC_FIRST_RST   = 8'hA5;
    localparam logic [7:0] SYNC_SECOND_RST  = 8'h5A;
    localparam logic [7:0] STATE_TYPE_RST   = 8'h81;
    localparam logic [7:0] STATE_LENGTH_RST = 8'd128;

    // Configuration register indexes.
    localparam logic [7:0] CFG_SYNC_FIRST   = 8'd0;
    localparam logic [7:0] CFG_SYNC_SECOND  = 8'd1;
    localparam logic [7:0] CFG_STATE_TYPE   = 8'd2;
    localparam logic [7:0] CFG_STATE_LENGTH = 8'd3;

    // Input item function codes.
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Result word width, padded to whole bytes.
    localparam int unsigned OUT_BITS = 192;

    // Sequencer states, one-hot.
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0_0000_0000_0001,
        S_CHK   = 13'b0_0000_0000_0010,
        S_H0    = 13'b0_0000_0000_0100,
        S_H1    = 13'b0_0000_0000_1000,
        S_H3    = 13'b0_0000_0001_0000,
        S_CL    = 13'b0_0000_0010_0000,
        S_CH    = 13'b0_0000_0100_0000,
        S_CRC   = 13'b0_0000_1000_0000,
        S_DEC   = 13'b0_0001_0000_0000,
        S_CPY   = 13'b0_0010_0000_0000,
        S_PRD   = 13'b0_0100_0000_0000,
        S_RESP  = 13'b0_1000_0000_0000,
        S_SPARE = 13'b1_0000_0000_0000
    } t_state;

    // Control of the shared CRC unit.
    typedef struct packed {
        logic init;
        logic step;
    } t_crc_ctl;

    // One byte of CRC16-CCITT, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/scfr_byte_ram.sv
// ----------------------------------------------------------------------------
// scfr_byte_ram
// Byte-wide memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module scfr_byte_ram #(
    parameter int unsigned DEPTH = scfr_pkg::BUF_DEPTH,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/scfr_crc_unit.sv
// ----------------------------------------------------------------------------
// scfr_crc_unit
// CRC16-CCITT accumulator that folds in one byte per cycle while step is set.
// ----------------------------------------------------------------------------
`default_nettype none

module scfr_crc_unit (
    input  wire logic              i_clk,
    input  wire scfr_pkg::t_crc_ctl i_ctl,
    input  wire logic [7:0]        i_byte,
    output logic      [15:0]       o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    // Init loads the seed, step folds in one byte.
    always_comb begin
        n_crc = r_crc;
        if (i_ctl.init) begin
            n_crc = scfr_pkg::CRC_INIT;
        end else if (i_ctl.step) begin
            n_crc = scfr_pkg::crc_byte(r_crc, i_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
    end

    assign o_crc = r_crc;

endmodule

`default_nettype wire

>>> hw/rtl/sync_crc_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// sync_crc_frame_receiver_unit
// Serial frame receiver: buffers bytes, hunts for sync, checks CRC16-CCITT
// and keeps the payload of the last good state frame for readback.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               contents
//  s         in         i_s_tvalid/o_s_tready   push byte or payload read
//  m         out        o_m_tvalid/i_m_tready   read data, frame count, stats
//  cfg       in         i_cfg_valid/o_cfg_ready register index and value
//
//  A read item looks up the payload store. A push with fewer than 8 bytes
//  buffered goes straight to the result; otherwise the buffer is scanned for
//  sync, an over-long length is dropped, an incomplete frame waits for more
//  bytes, and a complete frame is CRC-checked and, if kept, has its payload
//  copied: the single buffer read port walks header, CRC and payload copy one byte a cycle.
//  The result sits in an output register; the last state waits while the
//  previous result has not been taken.
//  Reset (synchronous, active low) empties the buffer and clears counters.
//  The input side is not ready while an item is being worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_crc_frame_receiver_unit #(
    parameter int unsigned MAX_PAYLOAD = scfr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input items
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [15:0]  i_s_tdata,   // [7:0] rx_byte, [15:8] read_index
    input  wire logic         i_s_tuser,   // [0] func
    // result items
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // [7:0] read_data, [12:8] frames_now, [28:13] frame_seq, [60:29] frames_ok,
    // [92:61] crc_errors, [124:93] length_errors, [156:125] sync_losses,
    // [188:157] unknown_types, [191:189] zero
    output logic [191:0]      o_m_tdata,
    // configuration writes
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [7:0]   i_cfg_index,
    input  wire logic [7:0]   i_cfg_data
);

    localparam int unsigned PAW = $clog2(MAX_PAYLOAD);
    localparam logic [8:0]  MAX_LEN = 9'(MAX_PAYLOAD);

    // Configuration registers.
    logic [7:0] r_sync_first, r_sync_second, r_state_type, r_state_length;

    // Buffer and frame control.
    scfr_pkg::t_state r_state, n_state;
    logic [7:0]  r_head, n_head;
    logic [7:0]  r_count, n_count;
    logic [7:0]  r_off, n_off;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_crc_lo, n_crc_lo, r_crc_hi, n_crc_hi;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_fseq, n_fseq;
    logic [7:0]  r_ridx, n_ridx;
    logic [7:0]  r_rdata, n_rdata;
    logic [4:0]  r_now, n_now;

    // Kept frame state and statistics.
    logic [7:0]  r_stored_len, n_stored_len;
    logic [15:0] r_seq, n_seq;
    logic [31:0] r_good, n_good, r_crc_bad, n_crc_bad, r_len_bad, n_len_bad;
    logic [31:0] r_sync_bad, n_sync_bad, r_type_bad, n_type_bad;

    // Output register.
    logic         r_m_valid, n_m_valid;
    logic [191:0] r_m_data, n_m_data;

    // Memory and CRC hookups.
    logic        s_accept;
    logic        buf_we;
    logic [7:0]  buf_rdata;
    logic        pay_we;
    logic [7:0]  pay_rdata;
    logic [7:0]  drop;
    logic [15:0] crc_val;
    scfr_pkg::t_crc_ctl crc_ctl;

    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == scfr_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;
    assign buf_we      = s_accept && (i_s_tuser == scfr_pkg::FUNC_PUSH) && (r_count != 8'hFF);

    // Receive buffer, circular, addressed relative to the head.
    scfr_byte_ram #(.DEPTH(scfr_pkg::BUF_DEPTH)) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_head + r_count),
        .i_wdata (i_s_tdata[7:0]),
        .i_raddr (n_head + n_off),
        .o_rdata (buf_rdata)
    );

    // Payload store of the last good state frame.
    scfr_byte_ram #(.DEPTH(MAX_PAYLOAD)) u_pay (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (PAW'(r_off - 8'd6)),
        .i_wdata (buf_rdata),
        .i_raddr (PAW'(i_s_tdata[15:8])),
        .o_rdata (pay_rdata)
    );

    // Shared CRC unit.
    scfr_crc_unit u_crc (
        .i_clk  (i_clk),
        .i_ctl  (crc_ctl),
        .i_byte (buf_rdata),
        .o_crc  (crc_val)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first   <= scfr_pkg::SYNC_FIRST_RST;
            r_sync_second  <= scfr_pkg::SYNC_SECOND_RST;
            r_state_type   <= scfr_pkg::STATE_TYPE_RST;
            r_state_length <= scfr_pkg::STATE_LENGTH_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == scfr_pkg::CFG_SYNC_FIRST) begin
                r_sync_first <= i_cfg_data;
            end
            if (i_cfg_index == scfr_pkg::CFG_SYNC_SECOND) begin
                r_sync_second <= i_cfg_data;
            end
            if (i_cfg_index == scfr_pkg::CFG_STATE_TYPE) begin
                r_state_type <= i_cfg_data;
            end
            if (i_cfg_index == scfr_pkg::CFG_STATE_LENGTH) begin
                r_state_length <= i_cfg_data;
            end
        end
    end

    // Sequencer: header checks, CRC walk, payload copy, payload reads and results.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_off        = r_off;
        n_len        = r_len;
        n_crc_lo     = r_crc_lo;
        n_crc_hi     = r_crc_hi;
        n_type       = r_type;
        n_fseq       = r_fseq;
        n_ridx       = r_ridx;
        n_rdata      = r_rdata;
        n_now        = r_now;
        n_stored_len = r_stored_len;
        n_seq        = r_seq;
        n_good       = r_good;
        n_crc_bad    = r_crc_bad;
        n_len_bad    = r_len_bad;
        n_sync_bad   = r_sync_bad;
        n_type_bad   = r_type_bad;
        n_m_valid    = r_m_valid;
        n_m_data     = r_m_data;
        drop         = 8'd0;
        pay_we       = 1'b0;
        crc_ctl      = '0;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            scfr_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_now   = 5'd0;
                    n_rdata = 8'd0;
                    n_ridx  = i_s_tdata[15:8];
                    if (i_s_tuser == scfr_pkg::FUNC_PUSH) begin
                        if (r_count != 8'hFF) begin
                            n_count = r_count + 8'd1;
                        end
                        n_state = scfr_pkg::S_CHK;
                    end else begin
                        n_state = scfr_pkg::S_PRD;
                    end
                end
            end
            scfr_pkg::S_CHK: begin
                n_off = 8'd0;
                if (r_count < scfr_pkg::HDR_BYTES) begin
                    n_state = scfr_pkg::S_RESP;
                end else begin
                    n_state = scfr_pkg::S_H0;
                end
            end
            scfr_pkg::S_H0: begin
                if (buf_rdata != r_sync_first) begin
                    drop       = 8'd1;
                    n_sync_bad = r_sync_bad + 32'd1;
                    n_state    = scfr_pkg::S_CHK;
                end else begin
                    n_off   = 8'd1;
                    n_state = scfr_pkg::S_H1;
                end
            end
            scfr_pkg::S_H1: begin
                if (buf_rdata != r_sync_second) begin
                    drop       = 8'd1;
                    n_sync_bad = r_sync_bad + 32'd1;
                    n_state    = scfr_pkg::S_CHK;
                end else begin
                    n_off   = 8'd3;
                    n_state = scfr_pkg::S_H3;
                end
            end
            scfr_pkg::S_H3: begin
                if ({1'b0, buf_rdata} > MAX_LEN) begin
                    drop      = 8'd1;
                    n_len_bad = r_len_bad + 32'd1;
                    n_state   = scfr_pkg::S_CHK;
                end else if ({1'b0, r_count} <
                             ({1'b0, scfr_pkg::HDR_BYTES} + {1'b0, buf_rdata})) begin
                    // Frame not complete yet: wait for more bytes.
                    n_state = scfr_pkg::S_RESP;
                end else begin
                    n_len   = buf_rdata;
                    n_off   = buf_rdata + 8'd6;
                    n_state = scfr_pkg::S_CL;
                end
            end
            scfr_pkg::S_CL: begin
                n_crc_lo = buf_rdata;
                n_off    = r_len + 8'd7;
                n_state  = scfr_pkg::S_CH;
            end
            scfr_pkg::S_CH: begin
                n_crc_hi     = buf_rdata;
                n_off        = 8'd2;
                crc_ctl.init = 1'b1;
                n_state      = scfr_pkg::S_CRC;
            end
            scfr_pkg::S_CRC: begin
                // One byte per cycle, from type through the end of the payload.
                crc_ctl.step = 1'b1;
                if (r_off == 8'd2) begin
                    n_type = buf_rdata;
                end
                if (r_off == 8'd4) begin
                    n_fseq[7:0] = buf_rdata;
                end
                if (r_off == 8'd5) begin
                    n_fseq[15:8] = buf_rdata;
                end
                if (r_off == r_len + 8'd5) begin
                    n_state = scfr_pkg::S_DEC;
                end else begin
                    n_off = r_off + 8'd1;
                end
            end
            scfr_pkg::S_DEC: begin
                n_state = scfr_pkg::S_CHK;
                if (crc_val != {r_crc_hi, r_crc_lo}) begin
                    drop      = 8'd1;
                    n_crc_bad = r_crc_bad + 32'd1;
                end else if (r_type != r_state_type) begin
                    drop       = r_len + scfr_pkg::HDR_BYTES;
                    n_type_bad = r_type_bad + 32'd1;
                end else if (r_len != r_state_length) begin
                    drop      = r_len + scfr_pkg::HDR_BYTES;
                    n_len_bad = r_len_bad + 32'd1;
                end else begin
                    n_good       = r_good + 32'd1;
                    n_seq        = r_fseq;
                    n_stored_len = r_len;
                    if (r_now != 5'd31) begin
                        n_now = r_now + 5'd1;
                    end
                    if (r_len == 8'd0) begin
                        drop = scfr_pkg::HDR_BYTES;
                    end else begin
                        n_off   = 8'd6;
                        n_state = scfr_pkg::S_CPY;
                    end
                end
            end
            scfr_pkg::S_CPY: begin
                // Copy the payload into the store, then drop the whole frame.
                pay_we = 1'b1;
                if (r_off == r_len + 8'd5) begin
                    drop    = r_len + scfr_pkg::HDR_BYTES;
                    n_state = scfr_pkg::S_CHK;
                end else begin
                    n_off = r_off + 8'd1;
                end
            end
            scfr_pkg::S_PRD: begin
                if (r_ridx < r_stored_len) begin
                    n_rdata = pay_rdata;
                end
                n_state = scfr_pkg::S_RESP;
            end
            scfr_pkg::S_RESP: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {3'b000, r_type_bad, r_sync_bad, r_len_bad, r_crc_bad,
                                 r_good, r_seq, r_now, r_rdata};
                    n_state   = scfr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = scfr_pkg::S_IDLE;
            end
        endcase

        n_head  = r_head + drop;
        n_count = n_count - drop;
    end

    // Control and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= scfr_pkg::S_IDLE;
            r_head       <= 8'd0;
            r_count      <= 8'd0;
            r_stored_len <= 8'd0;
            r_seq        <= 16'd0;
            r_good       <= 32'd0;
            r_crc_bad    <= 32'd0;
            r_len_bad    <= 32'd0;
            r_sync_bad   <= 32'd0;
            r_type_bad   <= 32'd0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_count      <= n_count;
            r_stored_len <= n_stored_len;
            r_seq        <= n_seq;
            r_good       <= n_good;
            r_crc_bad    <= n_crc_bad;
            r_len_bad    <= n_len_bad;
            r_sync_bad   <= n_sync_bad;
            r_type_bad   <= n_type_bad;
            r_m_valid    <= n_m_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_off    <= n_off;
        r_len    <= n_len;
        r_crc_lo <= n_crc_lo;
        r_crc_hi <= n_crc_hi;
        r_type   <= n_type;
        r_fseq   <= n_fseq;
        r_ridx   <= n_ridx;
        r_rdata  <= n_rdata;
        r_now    <= n_now;
        r_m_data <= n_m_data;
    end

    // A scan always leaves room for the next byte.
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scfr_pkg::S_IDLE) |-> (r_count != 8'hFF))
        else $error("buffer full while idle");

    // The payload copy stays inside the payload bytes of the frame.
    a_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scfr_pkg::S_CPY) |-> (r_off >= 8'd6 && r_off <= r_len + 8'd5))
        else $error("payload copy out of range");

    // A new result only comes out of the result state.
    a_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state == scfr_pkg::S_RESP))
        else $error("result raised outside result state");

    // An accepted item starts work.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state != scfr_pkg::S_IDLE))
        else $error("accepted item left idle");

endmodule

`default_nettype wire
